>>> hdl/sorted_unique_port_merge_top_defines.svh
// Assertion macros shared by the port merge RTL.
`ifndef SORTED_UNIQUE_PORT_MERGE_TOP_DEFINES_SVH
`define SORTED_UNIQUE_PORT_MERGE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define SUPM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define SUPM_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define SUPM_ASSERT(lbl, clk, rstn, prop, msg)

`define SUPM_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

>>> hdl/supm_pkg.sv
package supm_pkg;

  localparam int unsigned MaxPortsDef = 64;
  localparam int unsigned PortW       = 16;
  localparam int unsigned UcountW     = 7;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned OutDataW    = ((PortW + UcountW + 7) / 8) * 8;

  typedef struct packed {
    logic [PortW-1:0] port;
    logic             last;
    logic             live;
  } supm_item_t;

  typedef struct packed {
    logic [PortW-1:0]   port;
    logic [UcountW-1:0] ucnt;
    logic               empty;
    logic               ovf;
    logic               last;
  } supm_result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_INS,
    BK_EMIT
  } supm_state_e;

endpackage

>>> hdl/supm_front.sv
`include "sorted_unique_port_merge_top_defines.svh"

module supm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [supm_pkg::PortW-1:0]   s_port_i,
  input  logic                         s_last_i,
  output logic                         q_valid_o,
  output supm_pkg::supm_item_t         q_item_o,
  input  logic                         q_pop_i
);
  import supm_pkg::*;

  localparam int unsigned PtrW  = $clog2(QueueDepth);
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  supm_item_t       mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             push;
  logic             full;
  supm_item_t       item_in;

  assign full      = fill_q == FillW'(QueueDepth);
  assign s_ready_o = !full;
  assign q_valid_o = fill_q != '0;
  assign q_item_o  = mem_q[rd_ptr_q];

  // drop zero ports unless they close the run
  assign item_in.port = s_port_i;
  assign item_in.last = s_last_i;
  assign item_in.live = s_port_i != '0;
  assign push = s_valid_i && !full && (s_last_i || item_in.live);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (!push && q_pop_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  `SUPM_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop_i && fill_q == '0, "pop from empty queue")
  `SUPM_ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q > FillW'(QueueDepth), "queue fill out of range")

endmodule

>>> hdl/supm_back.sv
`include "sorted_unique_port_merge_top_defines.svh"

module supm_back #(
  parameter int unsigned MaxPorts = supm_pkg::MaxPortsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  supm_pkg::supm_item_t   q_item_i,
  output logic                   q_pop_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output supm_pkg::supm_result_t res_o
);
  import supm_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPorts + 1);

  supm_state_e       state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic              ovf_q, ovf_d;
  supm_item_t        item_q;
  logic [PortW-1:0]  cell_q [MaxPorts];
  logic [MaxPorts-1:0] gt_q;
  logic [MaxPorts-1:0] eq_q;
  logic              ins;
  logic              shift;
  logic              load_out;
  logic              slot_free;
  logic              dup;
  logic              full;
  logic              out_valid_q, out_valid_d;
  supm_result_t      out_q, out_d;

  assign dup         = |eq_q;
  assign full        = count_q == CntW'(MaxPorts);
  assign slot_free   = !out_valid_q || res_ready_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rem_d    = rem_q;
    ovf_d    = ovf_q;
    q_pop_o  = 1'b0;
    ins      = 1'b0;
    shift    = 1'b0;
    load_out = 1'b0;
    out_d.port  = (count_q == '0) ? '0 : cell_q[0];
    out_d.ucnt  = UcountW'(count_q);
    out_d.empty = count_q == '0;
    out_d.ovf   = ovf_q;
    out_d.last  = (count_q == '0) || (rem_q == CntW'(1));
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = BK_INS;
        end
      end
      BK_INS: begin
        if (item_q.live && !dup) begin
          ins = 1'b1;
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        if (item_q.last) begin
          rem_d   = count_d;
          state_d = BK_EMIT;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (count_q == '0) begin
            state_d = BK_IDLE;
          end else begin
            shift = 1'b1;
            rem_d = rem_q - 1'b1;
            if (rem_q == CntW'(1)) begin
              count_d = '0;
              ovf_d   = 1'b0;
              state_d = BK_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
  end

  for (genvar k = 0; k < MaxPorts; k++) begin : g_cell
    logic [PortW-1:0] prev;
    logic [PortW-1:0] next;

    if (k == 0) begin : g_first
      assign prev = item_q.port;
    end else begin : g_rest
      assign prev = gt_q[k-1] ? cell_q[k-1] : item_q.port;
    end

    if (k == MaxPorts - 1) begin : g_tail
      assign next = cell_q[k];
    end else begin : g_body
      assign next = cell_q[k+1];
    end

    // compare flags against the queue head, then insert or shift down
    always_ff @(posedge clk_i) begin
      if (q_pop_o) begin
        gt_q[k] <= (CntW'(k) >= count_q) || (cell_q[k] > q_item_i.port);
        eq_q[k] <= (CntW'(k) < count_q) && (cell_q[k] == q_item_i.port);
      end
      if (ins) begin
        if (gt_q[k]) begin
          cell_q[k] <= prev;
        end
      end else if (shift) begin
        cell_q[k] <= next;
      end
    end
  end

  `SUPM_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CntW'(MaxPorts), "store count above capacity")
  `SUPM_ASSERT(a_empty_last, clk_i, rst_ni, out_valid_q && out_q.empty |-> out_q.last, "empty result without last")
  `SUPM_ASSERT(a_rem_live, clk_i, rst_ni, state_q == BK_EMIT && count_q != '0 |-> rem_q != '0, "emit with nothing left")
  `SUPM_ASSERT(a_eq_single, clk_i, rst_ni, state_q == BK_INS |-> $onehot0(eq_q), "port matched twice in store")

endmodule

>>> hdl/sorted_unique_port_merge_top.sv
// Channel   Dir  tdata (low bit up)                         tlast      tuser
// s_axis    in   port_value[15:0]                           last_item  -
// m_axis    out  port_number[15:0], unique_count[22:16], 0  is_last    empty_set, overflow
//
// Each nonzero port passes the sorter as a compare, then an insert;
// zero ports without a last mark are dropped at the input.
// A four-entry queue lets input beats arrive while the sorter inserts or emits.
// After the last beat the set leaves from cell 0, at one beat a cycle while m_axis_tready is high.
// Reset is asynchronous and needs no clearing pass; store cells are not reset.
// A stalled output holds the sorter while it emits; the input stalls only when the queue fills.
module sorted_unique_port_merge_top #(
  parameter int unsigned MAX_PORTS = supm_pkg::MaxPortsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [supm_pkg::PortW-1:0]    s_axis_tdata,  // port_value
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [supm_pkg::OutDataW-1:0] m_axis_tdata,  // port_number, unique_count, pad
  output logic                          m_axis_tlast,
  output logic [1:0]                    m_axis_tuser   // empty_set, overflow
);
  import supm_pkg::*;

  logic         q_valid;
  logic         q_pop;
  supm_item_t   q_item;
  supm_result_t res;

  supm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_port_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  supm_back #(
    .MaxPorts (MAX_PORTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {(OutDataW - PortW - UcountW)'(0), res.ucnt, res.port};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = {res.ovf, res.empty};

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import supm_pkg::*;

  localparam int unsigned SetDepth   = MaxPortsDef;
  localparam int unsigned RandItems  = 420;
  localparam int unsigned CalmBeats  = 40;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [PortW-1:0] port;
    logic             last;
  } port_beat_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PortW-1:0]    s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic [1:0]          m_axis_tuser;

  port_beat_t          port_beats_q[$];
  supm_result_t        sorted_ports_q[$];
  logic [PortW-1:0]    set_mem[SetDepth];
  int unsigned         set_count    = 0;
  logic                set_ovf      = 1'b0;
  int unsigned         beat_total   = 0;
  int unsigned         mismatches   = 0;
  int unsigned         cycle_count  = 0;
  int unsigned         in_gap       = 0;
  int unsigned         out_gap      = 0;

  sorted_unique_port_merge_top #(
    .MAX_PORTS(SetDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // port_value
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // port_number, unique_count, pad
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)    // empty_set, overflow
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit calm_phase();
    return port_beats_q.size() < CalmBeats;
  endfunction

  function automatic void insert_port(input logic [PortW-1:0] p);
    int unsigned pos;
    int unsigned k;
    if (p == '0) return;
    pos = 0;
    while (pos < set_count && set_mem[pos] < p) pos++;
    if (pos < set_count && set_mem[pos] == p) return;
    if (set_count >= SetDepth) begin
      set_ovf = 1'b1;
      if (pos >= SetDepth) return;
      for (k = SetDepth - 1; k > pos; k--) set_mem[k] = set_mem[k-1];
      set_mem[pos] = p;
      return;
    end
    for (k = set_count; k > pos; k--) set_mem[k] = set_mem[k-1];
    set_mem[pos] = p;
    set_count++;
  endfunction

  function automatic void flush_port_set();
    int unsigned i;
    if (set_count == 0) begin
      sorted_ports_q.push_back('{port: '0, ucnt: '0, empty: 1'b1, ovf: 1'b0, last: 1'b1});
    end else begin
      for (i = 0; i < set_count; i++) begin
        sorted_ports_q.push_back('{port: set_mem[i], ucnt: set_count[UcountW-1:0],
                                   empty: 1'b0, ovf: set_ovf, last: (i + 1 == set_count)});
      end
    end
    set_count = 0;
    set_ovf   = 1'b0;
  endfunction

  task automatic add_beat(input logic [PortW-1:0] p, input logic l);
    port_beats_q.push_back('{port: p, last: l});
    beat_total++;
  endtask

  task automatic add_random_run();
    int unsigned kind;
    int unsigned len;
    int unsigned mode;
    int unsigned i;
    logic [PortW-1:0] p;
    kind = $urandom_range(0, 11);
    len  = (kind == 0) ? $urandom_range(66, 90) : $urandom_range(1, 16);
    mode = $urandom_range(0, 2);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) p = '0;
      else if (kind == 0 || mode == 0) p = PortW'($urandom_range(1, 65535));
      else if (mode == 1) p = PortW'($urandom_range(1, 8));
      else p = PortW'($urandom_range(65528, 65535));
      add_beat(p, i + 1 == len);
    end
  endtask

  always @(posedge clk_i) begin : drive_proc
    logic             nv;
    logic [PortW-1:0] nd;
    logic             nl;
    port_beat_t       b;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    nl = s_axis_tlast;
    if (!rst_ni) begin
      nv = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        insert_port(s_axis_tdata);
        if (s_axis_tlast) flush_port_set();
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (port_beats_q.size() != 0) begin
          if (!calm_phase() && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(0, 10);
          end else begin
            b  = port_beats_q.pop_front();
            nv = 1'b1;
            nd = b.port;
            nl = b.last;
          end
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
    s_axis_tlast  <= nl;
  end

  always @(posedge clk_i) begin : monitor_proc
    supm_result_t got;
    supm_result_t want;
    logic         rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{port: m_axis_tdata[PortW-1:0], ucnt: m_axis_tdata[PortW +: UcountW],
                empty: m_axis_tuser[0], ovf: m_axis_tuser[1], last: m_axis_tlast};
        if (sorted_ports_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: port %0d cnt %0d empty %0b ovf %0b last %0b",
                     got.port, got.ucnt, got.empty, got.ovf, got.last);
        end else begin
          want = sorted_ports_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d/%0d/%0b/%0b/%0b got %0d/%0d/%0b/%0b/%0b",
                       want.port, want.ucnt, want.empty, want.ovf, want.last,
                       got.port, got.ucnt, got.empty, got.ovf, got.last);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
      end else if (!calm_phase() && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 10);
      end else begin
        rdy = 1'b1;
      end
    end
    m_axis_tready <= rdy;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stim_proc
    int unsigned i;
    add_beat(16'd0, 1'b1);
    add_beat(16'd0, 1'b0);
    add_beat(16'd0, 1'b1);
    add_beat(16'hFFFF, 1'b0);
    add_beat(16'd1, 1'b0);
    add_beat(16'hFFFF, 1'b0);
    add_beat(16'd0, 1'b0);
    add_beat(16'd1, 1'b1);
    add_beat(16'h5555, 1'b0);
    add_beat(16'hAAAA, 1'b1);
    add_beat(16'd7, 1'b1);
    add_beat(16'd300, 1'b0);
    add_beat(16'd200, 1'b0);
    add_beat(16'd100, 1'b0);
    add_beat(16'd200, 1'b1);
    add_beat(16'd42, 1'b0);
    add_beat(16'd0, 1'b1);
    // fill the store exactly, arriving in descending order
    for (i = 0; i < SetDepth; i++) add_beat(16'(1000 + 7 * (SetDepth - 1 - i)), i + 1 == SetDepth);
    for (i = 0; i < 70; i++) add_beat(PortW'($urandom_range(1, 65535)), i == 69);
    while (beat_total < RandItems) add_random_run();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (port_beats_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (sorted_ports_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && sorted_ports_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/supm_pkg.sv
hdl/supm_front.sv
hdl/supm_back.sv
hdl/sorted_unique_port_merge_top.sv
tb/tb_top.sv
